[sv/pedometer_step_detector_top_assert.svh]
// ----------------------------------------------------------------------------
// Pedometer step detector assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PEDOMETER_STEP_DETECTOR_TOP_ASSERT_SVH
`define PEDOMETER_STEP_DETECTOR_TOP_ASSERT_SVH

// Property checked only outside reset.
`define PSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PSD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/psd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedometer step detector package
// Widths, codes, reset values, controller types and saturation helper.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int LOWPASS_TAPS_DEF  = 16;
   localparam int BANDPASS_TAPS_DEF = 32;

   localparam int AXES       = 3;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 32;
   localparam int VAL_W      = 48;
   localparam int PROD_W     = 96;
   localparam int ACC_W      = 56;
   localparam int SQ_W       = 98;
   localparam int DIV_W      = 59;
   localparam int STEP_W     = 16;
   localparam int IDX_W      = 6;
   localparam int GRAV_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int SHIFT_W    = 5;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 72;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // Register reset values.
   localparam logic signed [VAL_W-1:0] PEAK_RESET      = 48'sd5500;
   localparam logic signed [VAL_W-1:0] LOW_RESET       = 48'sd0;
   localparam logic [GRAV_W-1:0]       GRAV_LOW_RESET  = 16'd350;
   localparam logic [GRAV_W-1:0]       GRAV_HIGH_RESET = 16'd450;
   localparam logic [BYTE_W-1:0]       WEIGHT_RESET    = 8'd2;
   localparam logic [BYTE_W-1:0]       TOTAL_RESET     = 8'd10;
   localparam logic [SHIFT_W-1:0]      LP_SHIFT_RESET  = 5'd8;
   localparam logic [SHIFT_W-1:0]      BP_SHIFT_RESET  = 5'd8;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE  = 2'd0,
      OP_LP_COEF = 2'd1,
      OP_BP_COEF = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PEAK      = 3'd0,
      CSR_LOW       = 3'd1,
      CSR_GRAV_LOW  = 3'd2,
      CSR_GRAV_HIGH = 3'd3,
      CSR_WEIGHT    = 3'd4,
      CSR_TOTAL     = 3'd5,
      CSR_LP_SHIFT  = 3'd6,
      CSR_BP_SHIFT  = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      MS_LP  = 2'd0,
      MS_DOT = 2'd1,
      MS_SQ  = 2'd2,
      MS_BP  = 2'd3
   } mul_sel_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE,
      S_LP_ISSUE, S_LP_WAIT, S_GRAV,
      S_DOT_ISSUE, S_DOT_WAIT, S_SQ_ISSUE, S_SQ_WAIT,
      S_BP_PUSH, S_BP_ISSUE, S_BP_WAIT, S_RAW,
      S_EWMA_MUL, S_DIV_START, S_DIV_WAIT, S_DONE
   } state_type;

   typedef struct packed {
      logic        load;
      logic        coef_write;
      logic        sample_push;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        grav_latch;
      logic        axis_next;
      logic        bp_push;
      logic        raw_latch;
      logic        ewma_mul;
      logic        div_start;
      logic        finish;
   } psd_cmd_type;

   typedef struct packed {
      logic op_sample;
      logic first;
      logic tap_last;
      logic axis_last;
      logic mul_done;
      logic div_done;
   } psd_status_type;

   // Clamp a wide signed value to the 48-bit range.
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [PROD_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > PROD_W'(VAL_MAX)) begin
         r = VAL_MAX;
      end else if (v < PROD_W'(VAL_MIN)) begin
         r = VAL_MIN;
      end else begin
         r = VAL_W'(v);
      end
      return r;
   endfunction

endpackage

[sv/psd_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 48 x 48 multiply in three 16-bit passes over the second operand.
// ----------------------------------------------------------------------------
module psd_mul import psd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [VAL_W-1:0]  a_in,
   input  logic signed [VAL_W-1:0]  b_in,
   output logic                     done,
   output logic signed [PROD_W-1:0] product
);

   localparam int CHUNK_W = 16;

   logic                      busy_ff;
   logic                      done_ff;
   logic [1:0]                cnt_ff;
   logic signed [VAL_W-1:0]   a_ff;
   logic signed [VAL_W-1:0]   b_ff;
   logic signed [PROD_W-1:0]  acc_ff;
   logic signed [CHUNK_W:0]   chunk;
   logic signed [VAL_W+CHUNK_W:0] partial;
   logic signed [PROD_W-1:0]  shifted;

   // Lower chunks are unsigned, the top chunk carries the sign.
   always_comb begin
      case (cnt_ff)
         2'd0:    chunk = $signed({1'b0, b_ff[CHUNK_W-1:0]});
         2'd1:    chunk = $signed({1'b0, b_ff[2*CHUNK_W-1:CHUNK_W]});
         default: chunk = $signed({b_ff[VAL_W-1], b_ff[VAL_W-1:2*CHUNK_W]});
      endcase
      partial = a_ff * chunk;
      shifted = PROD_W'(partial) <<< {cnt_ff, 4'b0000};
   end

   // Control of the passes.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands and partial-product accumulator.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + shifted;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[sv/psd_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothing divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psd_div import psd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [BYTE_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [BYTE_W-1:0] rem_ff;
   logic [BYTE_W-1:0] div_ff;
   logic [BYTE_W:0]   trial;
   logic [BYTE_W:0]   diff;
   logic              ge;

   // One trial subtraction per cycle.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, div_ff};
      ge    = (trial >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= ge ? diff[BYTE_W-1:0] : trial[BYTE_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/psd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedometer datapath
// Registers, filter lines, coefficient tables, shared arithmetic and result.
// ----------------------------------------------------------------------------
module psd_datapath import psd_pkg::*; #(
   parameter int LOWPASS_TAPS  = LOWPASS_TAPS_DEF,
   parameter int BANDPASS_TAPS = BANDPASS_TAPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  psd_cmd_type           cmd,
   output psd_status_type        status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VAL_W-1:0]      csr_data,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int LP_AW = (LOWPASS_TAPS > 1) ? $clog2(LOWPASS_TAPS) : 1;
   localparam int BP_AW = (BANDPASS_TAPS > 1) ? $clog2(BANDPASS_TAPS) : 1;
   localparam logic [LP_AW-1:0] LP_LAST = LP_AW'(LOWPASS_TAPS - 1);
   localparam logic [BP_AW-1:0] BP_LAST = BP_AW'(BANDPASS_TAPS - 1);

   // Configuration registers.
   logic signed [VAL_W-1:0] peak_ff, low_ff;
   logic [GRAV_W-1:0]       glow_ff, ghigh_ff;
   logic [BYTE_W-1:0]       weight_ff, total_ff;
   logic [SHIFT_W-1:0]      lps_ff, bps_ff;

   // Latched item.
   op_type                     op_ff;
   logic signed [SAMPLE_W-1:0] sample_ff [AXES];
   logic [IDX_W-1:0]           idx_ff;
   logic signed [COEF_W-1:0]   coefv_ff;

   // Filter storage.
   logic signed [SAMPLE_W-1:0] lp_line_ff [AXES][LOWPASS_TAPS];
   logic signed [COEF_W-1:0]   lp_coef_ff [LOWPASS_TAPS];
   logic [LP_AW-1:0]           lp_ptr_ff;
   logic signed [VAL_W-1:0]    bp_line_ff [BANDPASS_TAPS];
   logic signed [COEF_W-1:0]   bp_coef_ff [BANDPASS_TAPS];
   logic [BP_AW-1:0]           bp_ptr_ff;

   // Work registers.
   logic [LP_AW-1:0]         lp_tap_ff;
   logic [BP_AW-1:0]         bp_tap_ff;
   logic [1:0]               axis_ff;
   mul_sel_type              mul_sel_ff;
   logic signed [ACC_W-1:0]  acc_ff, dot_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic signed [VAL_W-1:0]  grav_ff, user_ff, raw_ff;
   logic signed [56:0]       ew_w_ff;
   logic signed [57:0]       ew_p_ff;
   logic [BYTE_W-1:0]        tot_eff_ff;
   logic                     neg_ff, grav_ok_ff;

   // Persistent detector state.
   logic signed [VAL_W-1:0] prev_ff;
   logic                    first_ff, below_ff;
   logic [STEP_W-1:0]       steps_ff;

   // Result register.
   logic [STEP_W-1:0]       res_steps_ff;
   logic                    res_now_ff, res_ok_ff;
   logic signed [VAL_W-1:0] res_smooth_ff;

   // Combinational signals.
   logic [LP_AW-1:0]         lp_ptr_dec, lp_rd_idx;
   logic [LP_AW:0]           lp_sum;
   logic [BP_AW-1:0]         bp_ptr_dec, bp_rd_idx;
   logic [BP_AW:0]           bp_sum;
   logic signed [VAL_W-1:0]  mul_a, mul_b;
   logic                     mul_done, div_done;
   logic signed [PROD_W-1:0] mul_prod;
   logic [SHIFT_W-1:0]       shamt;
   logic signed [VAL_W-1:0]  tap_term, grav_next, user_next, dot_sat;
   logic signed [VAL_W:0]    user_diff;
   logic [BYTE_W-1:0]        tot_eff;
   logic signed [BYTE_W:0]   w_s;
   logic signed [BYTE_W+1:0] tw;
   logic signed [56:0]       ew_w_in;
   logic signed [57:0]       ew_p_in;
   logic [31:0]              gh2;
   logic [GRAV_W:0]          gl1;
   logic [33:0]              gl2;
   logic                     grav_ok_in;
   logic signed [DIV_W-1:0]  ew_sum;
   logic [DIV_W-1:0]         ew_mag;
   logic [DIV_W-1:0]         quot;
   logic signed [DIV_W:0]    q_signed;
   logic signed [VAL_W-1:0]  smooth_div;
   logic                     step_c, below_in;
   logic [STEP_W-1:0]        steps_in;

   // Circular line addressing.
   always_comb begin
      lp_ptr_dec = (lp_ptr_ff == '0) ? LP_LAST : lp_ptr_ff - 1'b1;
      bp_ptr_dec = (bp_ptr_ff == '0) ? BP_LAST : bp_ptr_ff - 1'b1;
      lp_sum     = {1'b0, lp_ptr_ff} + {1'b0, lp_tap_ff};
      bp_sum     = {1'b0, bp_ptr_ff} + {1'b0, bp_tap_ff};
      lp_rd_idx  = (lp_sum >= (LP_AW+1)'(LOWPASS_TAPS)) ?
                   LP_AW'(lp_sum - (LP_AW+1)'(LOWPASS_TAPS)) : LP_AW'(lp_sum);
      bp_rd_idx  = (bp_sum >= (BP_AW+1)'(BANDPASS_TAPS)) ?
                   BP_AW'(bp_sum - (BP_AW+1)'(BANDPASS_TAPS)) : BP_AW'(bp_sum);
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (cmd.mul_sel)
         MS_LP: begin
            mul_a = VAL_W'(lp_line_ff[axis_ff][lp_rd_idx]);
            mul_b = VAL_W'(lp_coef_ff[lp_tap_ff]);
         end
         MS_DOT: begin
            mul_a = user_ff;
            mul_b = grav_ff;
         end
         MS_SQ: begin
            mul_a = grav_ff;
            mul_b = grav_ff;
         end
         default: begin
            mul_a = bp_line_ff[bp_rd_idx];
            mul_b = VAL_W'(bp_coef_ff[bp_tap_ff]);
         end
      endcase
   end

   psd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Tap product scaling, gravity and user acceleration.
   always_comb begin
      shamt     = (mul_sel_ff == MS_BP) ? bps_ff : lps_ff;
      tap_term  = sat_val(mul_prod >>> shamt);
      grav_next = sat_val(PROD_W'(acc_ff));
      user_diff = (VAL_W+1)'(sample_ff[axis_ff]) - (VAL_W+1)'(grav_next);
      user_next = sat_val(PROD_W'(user_diff));
      dot_sat   = sat_val(PROD_W'(dot_ff));
   end

   // Smoothing products, gravity window and divider operands.
   always_comb begin
      tot_eff    = (total_ff == '0) ? 8'd1 : total_ff;
      w_s        = $signed({1'b0, weight_ff});
      tw         = $signed({2'b00, tot_eff}) - $signed({2'b00, weight_ff});
      ew_w_in    = w_s * raw_ff;
      ew_p_in    = tw * prev_ff;
      gh2        = ghigh_ff * ghigh_ff;
      gl1        = {1'b0, glow_ff} + 17'd1;
      gl2        = gl1 * gl1;
      grav_ok_in = (sq_ff < SQ_W'(gh2)) && (sq_ff >= SQ_W'(gl2));
      ew_sum     = DIV_W'(ew_w_ff) + DIV_W'(ew_p_ff);
      ew_mag     = ew_sum[DIV_W-1] ? DIV_W'(-ew_sum) : DIV_W'(ew_sum);
   end

   psd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ew_mag),
      .divisor  (tot_eff_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // Signed smoothed value and hysteresis step decision.
   always_comb begin
      q_signed   = neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      smooth_div = sat_val(PROD_W'(q_signed));
      step_c     = 1'b0;
      below_in   = below_ff;
      steps_in   = steps_ff;
      if (grav_ok_ff) begin
         if (below_ff) begin
            if (smooth_div > peak_ff) begin
               steps_in = steps_ff + 1'b1;
               below_in = 1'b0;
               step_c   = 1'b1;
            end
         end else if (smooth_div < low_ff) begin
            below_in = 1'b1;
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff   <= PEAK_RESET;
         low_ff    <= LOW_RESET;
         glow_ff   <= GRAV_LOW_RESET;
         ghigh_ff  <= GRAV_HIGH_RESET;
         weight_ff <= WEIGHT_RESET;
         total_ff  <= TOTAL_RESET;
         lps_ff    <= LP_SHIFT_RESET;
         bps_ff    <= BP_SHIFT_RESET;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PEAK:      peak_ff   <= csr_data;
            CSR_LOW:       low_ff    <= csr_data;
            CSR_GRAV_LOW:  glow_ff   <= csr_data[GRAV_W-1:0];
            CSR_GRAV_HIGH: ghigh_ff  <= csr_data[GRAV_W-1:0];
            CSR_WEIGHT:    weight_ff <= csr_data[BYTE_W-1:0];
            CSR_TOTAL:     total_ff  <= csr_data[BYTE_W-1:0];
            CSR_LP_SHIFT:  lps_ff    <= csr_data[SHIFT_W-1:0];
            CSR_BP_SHIFT:  bps_ff    <= csr_data[SHIFT_W-1:0];
         endcase
      end
   end

   // Item capture and sequencing registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= op_type'(req_tuser);
         sample_ff[0] <= req_tdata[15:0];
         sample_ff[1] <= req_tdata[31:16];
         sample_ff[2] <= req_tdata[47:32];
         idx_ff       <= req_tdata[53:48];
         coefv_ff     <= req_tdata[85:54];
         acc_ff       <= '0;
         dot_ff       <= '0;
         sq_ff        <= '0;
         lp_tap_ff    <= '0;
         bp_tap_ff    <= '0;
         axis_ff      <= 2'd0;
      end else begin
         if (cmd.mul_start) begin
            mul_sel_ff <= cmd.mul_sel;
         end
         if (mul_done) begin
            case (mul_sel_ff)
               MS_LP: begin
                  acc_ff    <= acc_ff + ACC_W'(tap_term);
                  lp_tap_ff <= lp_tap_ff + 1'b1;
               end
               MS_BP: begin
                  acc_ff    <= acc_ff + ACC_W'(tap_term);
                  bp_tap_ff <= bp_tap_ff + 1'b1;
               end
               MS_DOT:  dot_ff <= dot_ff + ACC_W'(sat_val(mul_prod));
               default: sq_ff  <= sq_ff + SQ_W'($unsigned(mul_prod));
            endcase
         end
         if (cmd.grav_latch) begin
            grav_ff   <= grav_next;
            user_ff   <= user_next;
            acc_ff    <= '0;
            lp_tap_ff <= '0;
         end
         if (cmd.axis_next) begin
            axis_ff <= axis_ff + 2'd1;
         end
         if (cmd.bp_push) begin
            acc_ff    <= '0;
            bp_tap_ff <= '0;
         end
         if (cmd.raw_latch) begin
            raw_ff <= grav_next;
         end
         if (cmd.ewma_mul) begin
            ew_w_ff    <= ew_w_in;
            ew_p_ff    <= ew_p_in;
            tot_eff_ff <= tot_eff;
            grav_ok_ff <= grav_ok_in;
         end
         if (cmd.div_start) begin
            neg_ff <= ew_sum[DIV_W-1];
         end
      end
   end

   // Delay lines and coefficient tables.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOWPASS_TAPS; i++) begin
            lp_coef_ff[i] <= '0;
            for (int a = 0; a < AXES; a++) begin
               lp_line_ff[a][i] <= '0;
            end
         end
         for (int j = 0; j < BANDPASS_TAPS; j++) begin
            bp_coef_ff[j] <= '0;
            bp_line_ff[j] <= '0;
         end
         lp_ptr_ff <= '0;
         bp_ptr_ff <= '0;
      end else begin
         if (cmd.coef_write) begin
            if (op_ff == OP_LP_COEF && int'(idx_ff) < LOWPASS_TAPS) begin
               lp_coef_ff[LP_AW'(idx_ff)] <= coefv_ff;
            end
            if (op_ff == OP_BP_COEF && int'(idx_ff) < BANDPASS_TAPS) begin
               bp_coef_ff[BP_AW'(idx_ff)] <= coefv_ff;
            end
         end
         if (cmd.sample_push) begin
            lp_ptr_ff <= lp_ptr_dec;
            for (int a = 0; a < AXES; a++) begin
               lp_line_ff[a][lp_ptr_dec] <= sample_ff[a];
            end
         end
         if (cmd.bp_push) begin
            bp_ptr_ff             <= bp_ptr_dec;
            bp_line_ff[bp_ptr_dec] <= dot_sat;
         end
      end
   end

   // Detector state update and result capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         first_ff <= 1'b1;
         below_ff <= 1'b1;
         steps_ff <= '0;
      end else if (cmd.finish) begin
         if (op_ff == OP_SAMPLE) begin
            if (first_ff) begin
               first_ff      <= 1'b0;
               prev_ff       <= raw_ff;
               res_smooth_ff <= raw_ff;
               res_steps_ff  <= steps_ff;
               res_now_ff    <= 1'b0;
               res_ok_ff     <= 1'b0;
            end else begin
               prev_ff       <= smooth_div;
               below_ff      <= below_in;
               steps_ff      <= steps_in;
               res_smooth_ff <= smooth_div;
               res_steps_ff  <= steps_in;
               res_now_ff    <= step_c;
               res_ok_ff     <= grav_ok_ff;
            end
         end else begin
            res_smooth_ff <= prev_ff;
            res_steps_ff  <= steps_ff;
            res_now_ff    <= 1'b0;
            res_ok_ff     <= 1'b0;
         end
      end
   end

   // Status toward the controller.
   always_comb begin
      status.op_sample = (op_ff == OP_SAMPLE);
      status.first     = first_ff;
      status.tap_last  = (mul_sel_ff == MS_BP) ? (bp_tap_ff == BP_LAST)
                                               : (lp_tap_ff == LP_LAST);
      status.axis_last = (axis_ff == 2'(AXES - 1));
      status.mul_done  = mul_done;
      status.div_done  = div_done;
   end

   assign rsp_tdata = {6'd0, res_smooth_ff, res_ok_ff, res_now_ff, res_steps_ff};

endmodule

[sv/psd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedometer controller
// Sequences one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module psd_ctrl import psd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  psd_status_type status,
   output psd_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.op_sample) begin
               cmd.sample_push = 1'b1;
               state_in        = S_LP_ISSUE;
            end else begin
               cmd.coef_write = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_LP_ISSUE: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_LP;
            state_in      = S_LP_WAIT;
         end
         S_LP_WAIT: begin
            if (status.mul_done) begin
               state_in = status.tap_last ? S_GRAV : S_LP_ISSUE;
            end
         end
         S_GRAV: begin
            cmd.grav_latch = 1'b1;
            state_in       = S_DOT_ISSUE;
         end
         S_DOT_ISSUE: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_DOT;
            state_in      = S_DOT_WAIT;
         end
         S_DOT_WAIT: begin
            if (status.mul_done) begin
               state_in = S_SQ_ISSUE;
            end
         end
         S_SQ_ISSUE: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_SQ;
            state_in      = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (status.mul_done) begin
               if (status.axis_last) begin
                  state_in = S_BP_PUSH;
               end else begin
                  cmd.axis_next = 1'b1;
                  state_in      = S_LP_ISSUE;
               end
            end
         end
         S_BP_PUSH: begin
            cmd.bp_push = 1'b1;
            state_in    = S_BP_ISSUE;
         end
         S_BP_ISSUE: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_BP;
            state_in      = S_BP_WAIT;
         end
         S_BP_WAIT: begin
            if (status.mul_done) begin
               state_in = status.tap_last ? S_RAW : S_BP_ISSUE;
            end
         end
         S_RAW: begin
            cmd.raw_latch = 1'b1;
            state_in      = status.first ? S_DONE : S_EWMA_MUL;
         end
         S_EWMA_MUL: begin
            cmd.ewma_mul = 1'b1;
            state_in     = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[sv/pedometer_step_detector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedometer step detector
// Gravity low-pass, band-pass on the gravity dot product, smoothing and
// hysteresis step counting, one result per input item.
//
//   Channel   Direction  Handshake          Contents
//   req_      in         tvalid / tready    tuser: op; tdata: samples, coef
//   rsp_      out        tvalid / tready    tdata: step result
//   csr_      in         valid / ready      index, data (always ready)
//
// The time per sample is set by the shared three-pass multiplier and the
// one-bit-per-cycle divider; the first sample skips the smoothing.
// Synchronous reset zeroes the delay lines and coefficient tables at once.
// One item is in work at a time; a waiting result stalls only the finish.
// ----------------------------------------------------------------------------
module pedometer_step_detector_top import psd_pkg::*; #(
   parameter int LOWPASS_TAPS  = LOWPASS_TAPS_DEF,
   parameter int BANDPASS_TAPS = BANDPASS_TAPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // accel_x[15:0], accel_y[31:16], accel_z[47:32], coef_index[53:48],
   // coef_value[85:54], zero fill[87:86]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // step_count[15:0], step_now[16], gravity_ok[17], smoothed_value[65:18],
   // zero fill[71:66]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VAL_W-1:0]      csr_data
);

   psd_cmd_type    cmd;
   psd_status_type status;

   assign csr_ready = 1'b1;

   psd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   psd_datapath #(
      .LOWPASS_TAPS  (LOWPASS_TAPS),
      .BANDPASS_TAPS (BANDPASS_TAPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[sv/psd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pedometer port checker
// Port-level properties of the step detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "pedometer_step_detector_top_assert.svh"

module psd_checker import psd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [OP_W-1:0]       req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [VAL_W-1:0]      csr_data
);

   // No result is pending right after reset.
   `PSD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

   // A stalled result holds.
   `PSD_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // Items are worked one at a time.
   `PSD_ASSERT(a_one_item, req_tvalid && req_tready |=> !req_tready, "second item taken while busy")

   // A step is only counted inside the gravity window.
   `PSD_ASSERT(a_step_grav, rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[17], "step without gravity window")

endmodule

bind pedometer_step_detector_top psd_checker u_psd_checker (.*);
